// File: design/wip_pkg.sv
// shared constants, register codes and the configuration struct
// for the windowed integral pid controller; no dependencies
`default_nettype none

package wip_pkg;

    localparam int WINDOW_LEN_DEF = 50;

    localparam int SPEED_W   = 16;
    localparam int ERR_W     = 17;
    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int DRIVE_W   = 16;
    localparam int FRAC_BITS = 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_GAIN_P       = 2'd0;
    localparam reg_idx_t REG_GAIN_I       = 2'd1;
    localparam reg_idx_t REG_GAIN_D       = 2'd2;
    localparam reg_idx_t REG_OUTPUT_LIMIT = 2'd3;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST       = 16'sd256;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST       = 16'sd0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST       = 16'sd0;
    localparam logic        [LIMIT_W-1:0] OUTPUT_LIMIT_RST = 15'd5000;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic        [LIMIT_W-1:0] output_limit;
    } wip_cfg_t;

endpackage

`default_nettype wire

// File: design/wip_sample_if.sv
// sample request channel: measured and set speed
// depends on wip_pkg
`default_nettype none

interface wip_sample_if;
    import wip_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] measured_speed;
    logic signed [SPEED_W-1:0] set_speed;

    modport source (output valid, output measured_speed, output set_speed, input ready);
    modport sink   (input valid, input measured_speed, input set_speed, output ready);
endinterface

`default_nettype wire

// File: design/wip_drive_if.sv
// drive request channel: saturated controller output
// depends on wip_pkg
`default_nettype none

interface wip_drive_if;
    import wip_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_value;

    modport source (output valid, output drive_value, input ready);
    modport sink   (input valid, input drive_value, output ready);
endinterface

`default_nettype wire

// File: design/windowed_integral_pid.sv
// top level of the windowed integral pid speed controller
// depends on wip_pkg, wip_sample_if, wip_drive_if, wip_cfg, wip_window, wip_math
//
//   port     kind         carries
//   sample   valid/ready  measured_speed, set_speed (in)
//   drive    valid/ready  drive_value (out)
//   apb      psel/penable gain_p, gain_i, gain_d, output_limit at 0x0, 0x4, 0x8, 0xc
//
// one request per cycle sustained while drive.ready stays high; drive valid follows the
// sample accept through the input register and the output register
// stages: input register with window ram read and error, then gain products,
// sum, shift and clamp into the output register
// reset clears the window through per-entry fill flags, so no clearing pass is needed
// a stalled drive request holds the output register; sample.ready drops once the input register is full behind it
`default_nettype none

module windowed_integral_pid #(
    parameter int WINDOW_LEN = wip_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    wip_sample_if.sink                          sample,
    wip_drive_if.source                         drive,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wip_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [wip_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [wip_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import wip_pkg::*;

    localparam int SUM_W = ERR_W + $clog2(WINDOW_LEN);

    wip_cfg_t                cfg;
    logic                    s1_valid;
    logic                    s2_ready;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W:0]   der;
    logic signed [SUM_W-1:0] sum;

    wip_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wip_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (sample.valid),
        .in_ready       (sample.ready),
        .measured_speed (sample.measured_speed),
        .set_speed      (sample.set_speed),
        .s1_valid       (s1_valid),
        .s2_ready       (s2_ready),
        .err            (err),
        .der            (der),
        .sum            (sum)
    );

    wip_math #(
        .SUM_W (SUM_W)
    ) u_math (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s1_valid    (s1_valid),
        .s2_ready    (s2_ready),
        .err         (err),
        .der         (der),
        .sum         (sum),
        .out_valid   (drive.valid),
        .out_ready   (drive.ready),
        .drive_value (drive.drive_value)
    );

endmodule

`default_nettype wire

// File: design/wip_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module wip_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 50
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/wip_cfg.sv
// apb register file: gains and output limit
// depends on wip_pkg
`default_nettype none

module wip_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wip_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [wip_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [wip_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output wip_pkg::wip_cfg_t                      cfg
);
    import wip_pkg::*;

    wip_cfg_t cfg_reg;
    reg_idx_t reg_idx;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p       <= GAIN_P_RST;
            cfg_reg.gain_i       <= GAIN_I_RST;
            cfg_reg.gain_d       <= GAIN_D_RST;
            cfg_reg.output_limit <= OUTPUT_LIMIT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_GAIN_P:       cfg_reg.gain_p       <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:       cfg_reg.gain_i       <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:       cfg_reg.gain_d       <= pwdata[GAIN_W-1:0];
                REG_OUTPUT_LIMIT: cfg_reg.output_limit <= pwdata[LIMIT_W-1:0];
                default:          cfg_reg.gain_p       <= cfg_reg.gain_p;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GAIN_P:       prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_p};
            REG_GAIN_I:       prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_i};
            REG_GAIN_D:       prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_d};
            REG_OUTPUT_LIMIT: prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, cfg_reg.output_limit};
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: design/wip_window.sv
// first stage: error, derivative and the running window sum
// depends on wip_pkg and wip_ram
`default_nettype none

module wip_window #(
    parameter int WINDOW_LEN = wip_pkg::WINDOW_LEN_DEF,
    parameter int SUM_W      = wip_pkg::ERR_W + $clog2(WINDOW_LEN)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [wip_pkg::SPEED_W-1:0] measured_speed,
    input  wire logic signed [wip_pkg::SPEED_W-1:0] set_speed,
    output logic                                   s1_valid,
    input  wire logic                              s2_ready,
    output logic signed [wip_pkg::ERR_W-1:0]       err,
    output logic signed [wip_pkg::ERR_W:0]         der,
    output logic signed [SUM_W-1:0]                sum
);
    import wip_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_LEN);

    logic                    accept;
    logic                    advance;
    logic signed [ERR_W-1:0] err_in;
    logic [PTR_W-1:0]        ptr_reg;
    logic [PTR_W-1:0]        ptr_next;
    logic [WINDOW_LEN-1:0]   filled_reg;
    logic                    s1_valid_reg;
    logic signed [ERR_W-1:0] err1_reg;
    logic [PTR_W-1:0]        ptr1_reg;
    logic                    live1_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [ERR_W-1:0] prev_reg;
    logic [ERR_W-1:0]        rd_data;
    logic signed [ERR_W-1:0] old_err;

    assign in_ready = !s1_valid_reg || s2_ready;
    assign accept   = in_valid && in_ready;
    assign advance  = s1_valid_reg && s2_ready;

    assign err_in   = ERR_W'(set_speed) - ERR_W'(measured_speed);
    assign ptr_next = (ptr_reg == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_reg + 1'b1;

    // entries never written read as zero
    assign old_err  = live1_reg ? rd_data : '0;
    assign sum_next = sum_reg + SUM_W'(err1_reg) - SUM_W'(old_err);

    wip_ram #(
        .WIDTH (ERR_W),
        .DEPTH (WINDOW_LEN)
    ) u_window_ram (
        .clk     (clk),
        .wr_en   (advance),
        .wr_addr (ptr1_reg),
        .wr_data (err1_reg),
        .rd_en   (accept),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            filled_reg   <= '0;
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            prev_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                ptr_reg <= ptr_next;
            end
            if (advance)
            begin
                filled_reg[ptr1_reg] <= 1'b1;
                sum_reg              <= sum_next;
                prev_reg             <= err1_reg;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err1_reg  <= err_in;
            ptr1_reg  <= ptr_reg;
            live1_reg <= filled_reg[ptr_reg];
        end
    end

    assign s1_valid = s1_valid_reg;
    assign err      = err1_reg;
    assign der      = (ERR_W+1)'(err1_reg) - (ERR_W+1)'(prev_reg);
    assign sum      = sum_reg;

endmodule

`default_nettype wire

// File: design/wip_math.sv
// gain products, sum, shift and clamp feeding the output register
// depends on wip_pkg
`default_nettype none

module wip_math #(
    parameter int SUM_W = wip_pkg::ERR_W + $clog2(wip_pkg::WINDOW_LEN_DEF)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wip_pkg::wip_cfg_t                       cfg,
    input  wire logic                               s1_valid,
    output logic                                    s2_ready,
    input  wire logic signed [wip_pkg::ERR_W-1:0]   err,
    input  wire logic signed [wip_pkg::ERR_W:0]     der,
    input  wire logic signed [SUM_W-1:0]            sum,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [wip_pkg::DRIVE_W-1:0]      drive_value
);
    import wip_pkg::*;

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PD_W  = GAIN_W + ERR_W + 1;
    localparam int PI_W  = GAIN_W + SUM_W;
    localparam int ACC_W = PI_W + 2;
    localparam int Y_W   = ACC_W - FRAC_BITS;

    logic                      out_valid_reg;
    logic                      out_load_ok;
    logic                      load;
    logic signed [PP_W-1:0]    pp;
    logic signed [PI_W-1:0]    pi;
    logic signed [PD_W-1:0]    pd;
    logic signed [ACC_W-1:0]   acc;
    logic signed [Y_W-1:0]     y;
    logic signed [Y_W-1:0]     lim_pos;
    logic signed [Y_W-1:0]     lim_neg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic signed [DRIVE_W-1:0] drive_reg;

    assign out_load_ok = !out_valid_reg || out_ready;
    assign s2_ready    = out_load_ok;
    assign load        = s1_valid && out_load_ok;

    assign pp = cfg.gain_p * err;
    assign pi = cfg.gain_i * sum;
    assign pd = cfg.gain_d * der;

    assign acc     = ACC_W'(pp) + ACC_W'(pi) + ACC_W'(pd);
    // floor shift of the product sum, dropping the fraction bits of the q8.8 gains
    assign y       = acc[ACC_W-1:FRAC_BITS];
    assign lim_pos = Y_W'({1'b0, cfg.output_limit});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (y > lim_pos)
        begin
            drive_next = DRIVE_W'(lim_pos);
        end
        else if (y < lim_neg)
        begin
            drive_next = DRIVE_W'(lim_neg);
        end
        else
        begin
            drive_next = DRIVE_W'(y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load_ok)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_value = drive_reg;

endmodule

`default_nettype wire

// File: design/wip_checker.sv
// port-level checks on the windowed integral pid top level, bound to it
// depends on wip_pkg and windowed_integral_pid
`default_nettype none

module wip_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               sample_valid,
    input  wire logic                               sample_ready,
    input  wire logic                               drive_valid,
    input  wire logic                               drive_ready,
    input  wire logic signed [wip_pkg::DRIVE_W-1:0] drive_value
);
    import wip_pkg::*;

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       take_in;
    logic       take_out;

    assign take_in  = sample_valid && sample_ready;
    assign take_out = drive_valid && drive_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (take_in && !take_out)
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (take_out && !take_in)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // a result only exists for a request still in flight
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |-> (inflight_reg != 2'd0))
        else $error("drive request without a pending sample");

    // two register stages bound what can be in flight
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == 2'd2) |-> !(take_in && !take_out))
        else $error("more samples in flight than pipeline stages");

    // an empty pipeline always takes a sample
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == 2'd0) |-> sample_ready)
        else $error("sample refused with empty pipeline");

    a_drive_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_valid && !drive_ready) |=> (drive_valid && $stable(drive_value)))
        else $error("stalled drive request changed");

endmodule

bind windowed_integral_pid wip_checker u_wip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .drive_valid  (drive.valid),
    .drive_ready  (drive.ready),
    .drive_value  (drive.drive_value)
);

`default_nettype wire
